// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, all clocked on a rising edge and
// disabled while the active-low reset is asserted
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("assertion failed: invariant");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/sbmq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbmq_pkg
// shared types and constants of the shared-buffer multi-queue
// ---------------------------------------------------------------------------
package sbmq_pkg;

  localparam int unsigned SLOTS_DEF  = 64;
  localparam int unsigned QUEUES_DEF = 8;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned QNUM_W = 3;
  localparam int unsigned STAT_W = 2;

  // command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_UNDERFLOW = 2'd2;

  // strobes from the sequencer to the slot store
  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic data_we;
  } slot_ctl_t;

endpackage

// ===== rtl/shared_buffer_multi_queue_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shared_buffer_multi_queue_top
// several fifo queues chained through one shared slot store, with unused
// slots kept on a linked free list
// ---------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  input    | in_valid_i/in_stall_o | command_i, queue_number_i,
//           |                       | push_value_i
//  output   | out_valid_o/out_stall_i | pop_value_o, status_o
//
//  enqueue: the transfer starts the link read of the free-list head in S_RD,
//    which loads the result with the write-back; input is stalled until then
//  dequeue: the queue table read in S_RD gives the slot address for the link
//    and data read, and the result is loaded in S_DQ (underflow: in S_RD)
//  after reset a clearing pass over max(SLOTS, QUEUES) entries builds the
//    free list and empties the queue table; input is stalled meanwhile
//  a waiting result does not block the next input transfer; the sequencer
//    only holds in its last step while the result register is still full
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module shared_buffer_multi_queue_top import sbmq_pkg::*; #(
  parameter int unsigned SLOTS  = SLOTS_DEF,
  parameter int unsigned QUEUES = QUEUES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     command_i,
  input  logic [QNUM_W-1:0]        queue_number_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] pop_value_o,
  output logic [STAT_W-1:0]        status_o
);

  // slot index and pointer widths; a pointer equal to SLOTS means null
  localparam int unsigned IW    = $clog2(SLOTS);
  localparam int unsigned PW    = $clog2(SLOTS + 1);
  localparam int unsigned QAW   = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int unsigned CLR_N = (SLOTS > QUEUES) ? SLOTS : QUEUES;
  localparam int unsigned CW    = $clog2(CLR_N);
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  // sequencer states
  localparam logic [1:0] S_INIT = 2'd0;  // clearing pass
  localparam logic [1:0] S_IDLE = 2'd1;  // waiting for a transfer
  localparam logic [1:0] S_RD   = 2'd2;  // queue table and free link read back
  localparam logic [1:0] S_DQ   = 2'd3;  // dequeue slot read back

  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     clr_cnt_q, clr_cnt_d;
  logic [PW-1:0]     free_head_q, free_head_d;

  // latched input item
  logic              cmd_q;
  logic [QNUM_W-1:0] qnum_q;
  logic [DATA_W-1:0] val_q;
  logic              qok_q;

  // queue table: {head, tail} per queue
  logic [2*PW-1:0]   qt_mem [QUEUES];
  logic [2*PW-1:0]   qt_rd_q;
  logic              qt_re;
  logic              qt_we;
  logic [QAW-1:0]    qt_waddr;
  logic [2*PW-1:0]   qt_wdata;
  logic [PW-1:0]     qt_head;
  logic [PW-1:0]     qt_tail;

  // slot store ports
  slot_ctl_t         slot_ctl;
  logic [IW-1:0]     slot_rd_addr;
  logic [IW-1:0]     link_waddr;
  logic [PW-1:0]     link_wdata;
  logic [IW-1:0]     data_waddr;
  logic [DATA_W-1:0] data_wdata;
  logic [PW-1:0]     link_rdata;
  logic [DATA_W-1:0] data_rdata;

  // result register
  logic              out_valid_q;
  logic [DATA_W-1:0] pop_q, pop_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic              out_load;
  logic              out_free;

  logic accept;
  logic in_qok;
  logic free_ok;
  logic head_ok;
  logic tail_ok;
  logic link_ok;
  logic [PW-1:0] deq_next;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_qok  = (32'(queue_number_i) < QUEUES);
  assign qt_head = qt_rd_q[2*PW-1:PW];
  assign qt_tail = qt_rd_q[PW-1:0];
  assign free_ok = (free_head_q < NIL);
  assign head_ok = (qt_head < NIL);
  assign tail_ok = (qt_tail < NIL);
  assign link_ok = (link_rdata < NIL);

  // the tail slot's link is never refreshed on enqueue, so the last element
  // is recognized by comparing against the tail instead
  assign deq_next = (qt_head == qt_tail) ? NIL : (link_ok ? link_rdata : NIL);

  assign qt_re = accept && in_qok;

  // queue table memory
  always_ff @(posedge clk_i) begin
    if (qt_we) begin
      qt_mem[qt_waddr] <= qt_wdata;
    end
    if (qt_re) begin
      qt_rd_q <= qt_mem[QAW'(queue_number_i)];
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    free_head_d  = free_head_q;
    slot_ctl     = '0;
    slot_rd_addr = free_head_q[IW-1:0];
    link_waddr   = qt_tail[IW-1:0];
    link_wdata   = free_head_q;
    data_waddr   = free_head_q[IW-1:0];
    data_wdata   = val_q;
    qt_we        = 1'b0;
    qt_waddr     = QAW'(qnum_q);
    qt_wdata     = {NIL, NIL};
    out_load     = 1'b0;
    pop_d        = '0;
    status_d     = STATUS_OK;

    case (state_q)
      S_INIT: begin
        // slot i links to i + 1, the last one to null; queues start empty
        slot_ctl.link_we = (32'(clr_cnt_q) < SLOTS);
        link_waddr       = IW'(clr_cnt_q);
        link_wdata       = PW'(clr_cnt_q) + PW'(1);
        qt_we            = (32'(clr_cnt_q) < QUEUES);
        qt_waddr         = QAW'(clr_cnt_q);
        clr_cnt_d        = clr_cnt_q + CW'(1);
        if (32'(clr_cnt_q) == CLR_N - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d        = S_RD;
          slot_ctl.rd_en = (command_i == CMD_ENQ) && free_ok;
        end
      end
      S_RD: begin
        if (cmd_q == CMD_ENQ) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
            if (!qok_q || !free_ok) begin
              status_d = STATUS_OVERFLOW;
            end else begin
              // take the free-list head and append it to the queue
              free_head_d      = link_ok ? link_rdata : NIL;
              qt_we            = 1'b1;
              qt_wdata         = {(head_ok ? qt_head : free_head_q), free_head_q};
              slot_ctl.link_we = head_ok && tail_ok;
              link_waddr       = qt_tail[IW-1:0];
              link_wdata       = free_head_q;
              slot_ctl.data_we = 1'b1;
            end
          end
        end else if (!qok_q || !head_ok) begin
          if (out_free) begin
            out_load = 1'b1;
            status_d = STATUS_UNDERFLOW;
            state_d  = S_IDLE;
          end
        end else begin
          slot_ctl.rd_en = 1'b1;
          slot_rd_addr   = qt_head[IW-1:0];
          state_d        = S_DQ;
        end
      end
      S_DQ: begin
        if (out_free) begin
          // unlink the head and push its slot onto the free list
          out_load         = 1'b1;
          pop_d            = data_rdata;
          state_d          = S_IDLE;
          qt_we            = 1'b1;
          qt_wdata         = {deq_next, qt_tail};
          slot_ctl.link_we = 1'b1;
          link_waddr       = qt_head[IW-1:0];
          link_wdata       = free_head_q;
          free_head_d      = qt_head;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_cnt_q   <= '0;
      free_head_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      free_head_q <= free_head_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      qnum_q <= queue_number_i;
      val_q  <= push_value_i;
      qok_q  <= in_qok;
    end
    if (out_load) begin
      pop_q    <= pop_d;
      status_q <= status_d;
    end
  end

  sbmq_slot_store #(
    .SLOTS (SLOTS)
  ) u_slot_store (
    .clk_i        (clk_i),
    .ctl_i        (slot_ctl),
    .rd_addr_i    (slot_rd_addr),
    .link_addr_i  (link_waddr),
    .link_wdata_i (link_wdata),
    .data_addr_i  (data_waddr),
    .data_wdata_i (data_wdata),
    .link_rdata_o (link_rdata),
    .data_rdata_o (data_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign pop_value_o = pop_q;
  assign status_o    = status_q;

  // free pointer is a slot or null, never beyond
  `ASSERT_ALWAYS(a_free_head_range, clk_i, rst_ni, free_head_q <= NIL)
  // an enqueue never links the slot it is filling to itself
  `ASSERT_IMPLY(a_no_self_link, clk_i, rst_ni, slot_ctl.link_we && slot_ctl.data_we, link_waddr != data_waddr)
  // a transfer always starts the table read step
  `ASSERT_NEXT(a_accept_reads, clk_i, rst_ni, accept, state_q == S_RD)
  // a finished dequeue makes its slot the new free-list head
  `ASSERT_NEXT(a_deq_frees_slot, clk_i, rst_ni, (state_q == S_DQ) && out_free, free_head_q == $past(qt_head))

endmodule

// ===== rtl/sbmq_slot_store.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbmq_slot_store
// per-slot data words and next-slot links, one shared read address,
// separate write ports, registered read data
// ---------------------------------------------------------------------------
module sbmq_slot_store import sbmq_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  localparam int unsigned IW = $clog2(SLOTS),
  localparam int unsigned PW = $clog2(SLOTS + 1)
) (
  input  logic              clk_i,
  input  slot_ctl_t         ctl_i,
  input  logic [IW-1:0]     rd_addr_i,
  input  logic [IW-1:0]     link_addr_i,
  input  logic [PW-1:0]     link_wdata_i,
  input  logic [IW-1:0]     data_addr_i,
  input  logic [DATA_W-1:0] data_wdata_i,
  output logic [PW-1:0]     link_rdata_o,
  output logic [DATA_W-1:0] data_rdata_o
);

  logic [PW-1:0]     link_mem [SLOTS];
  logic [DATA_W-1:0] data_mem [SLOTS];
  logic [PW-1:0]     link_rd_q;
  logic [DATA_W-1:0] data_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.link_we) begin
      link_mem[link_addr_i] <= link_wdata_i;
    end
    if (ctl_i.rd_en) begin
      link_rd_q <= link_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.data_we) begin
      data_mem[data_addr_i] <= data_wdata_i;
    end
    if (ctl_i.rd_en) begin
      data_rd_q <= data_mem[rd_addr_i];
    end
  end

  assign link_rdata_o = link_rd_q;
  assign data_rdata_o = data_rd_q;

endmodule

// ===== verif/tb_shared_buffer_multi_queue_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_shared_buffer_multi_queue_top
// self-checking bench for the shared-buffer multi-queue: a slot-level model
// of the linked free list and the per-queue chains predicts each result,
// with directed corner cases first and then biased random traffic under
// three sender/receiver idle profiles
// ---------------------------------------------------------------------------
module tb_shared_buffer_multi_queue_top import sbmq_pkg::*;;

  localparam int unsigned NIL_SLOT     = SLOTS_DEF;  // null link in the model
  localparam int unsigned RAND_ITEMS   = 1550;
  localparam int unsigned CHUNK_ITEMS  = 80;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic [STAT_W-1:0]        status;
  } pop_result_t;

  // slot-level model of the queues plus the list of awaited results
  class queue_scoreboard;
    logic [DATA_W-1:0] slot_data [SLOTS_DEF];
    int unsigned       slot_link [SLOTS_DEF];
    int unsigned       head_slot [QUEUES_DEF];
    int unsigned       tail_slot [QUEUES_DEF];
    int unsigned       free_slot;
    pop_result_t       awaited_pops[$];
    int unsigned       mismatches;

    function new();
      for (int i = 0; i < SLOTS_DEF; i++) begin
        slot_data[i] = '0;
        slot_link[i] = i + 1;
      end
      for (int q = 0; q < QUEUES_DEF; q++) begin
        head_slot[q] = NIL_SLOT;
        tail_slot[q] = NIL_SLOT;
      end
      free_slot  = 0;
      mismatches = 0;
    endfunction

    // advance the model by one accepted command and queue its result
    function void apply_command(logic cmd, logic [QNUM_W-1:0] qn,
                                logic [DATA_W-1:0] value);
      pop_result_t res;
      int unsigned s;
      res.pop_value = '0;
      res.status    = STATUS_OK;
      if (cmd == CMD_ENQ) begin
        s = free_slot;
        if (s == NIL_SLOT) begin
          res.status = STATUS_OVERFLOW;
        end else begin
          free_slot = slot_link[s];
          // empty queue: new slot becomes head, a stale tail is just overwritten
          if (head_slot[qn] == NIL_SLOT) head_slot[qn] = s;
          else slot_link[tail_slot[qn]] = s;
          slot_data[s] = value;
          slot_link[s] = NIL_SLOT;
          tail_slot[qn] = s;
        end
      end else begin
        if (head_slot[qn] == NIL_SLOT) begin
          res.status = STATUS_UNDERFLOW;
        end else begin
          s = head_slot[qn];
          head_slot[qn] = slot_link[s];
          slot_link[s] = free_slot;
          free_slot = s;
          res.pop_value = slot_data[s];
        end
      end
      awaited_pops.push_back(res);
    endfunction

    function void compare_pop(logic signed [DATA_W-1:0] pop, logic [STAT_W-1:0] st);
      pop_result_t exp_res;
      if (awaited_pops.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: pop_value %h status %0d", pop, st);
        return;
      end
      exp_res = awaited_pops.pop_front();
      if (pop !== exp_res.pop_value || st !== exp_res.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected pop_value %h status %0d, got %h status %0d",
                   exp_res.pop_value, exp_res.status, pop, st);
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     command_i;
  logic [QNUM_W-1:0]        queue_number_i;
  logic signed [DATA_W-1:0] push_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] pop_value_o;
  logic [STAT_W-1:0]        status_o;

  queue_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     quiet_cycles = 0;

  shared_buffer_multi_queue_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .queue_number_i (queue_number_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pop_value_o    (pop_value_o),
    .status_o       (status_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // receiver side: sample at the edge (pre-update values), then redraw stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.compare_pop(pop_value_o, status_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles without any transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input transfer; valid stays high when no gap is drawn before the next
  task automatic send_command(input logic cmd, input logic [QNUM_W-1:0] qn,
                              input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    queue_number_i <= qn;
    push_value_i   <= value;
    do @(posedge clk_i); while (in_stall_o);
    sb.apply_command(cmd, qn, value);
  endtask

  // sender holds off until every awaited result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited_pops.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random_traffic();
    int unsigned enq_pct;
    int unsigned hot_queue;
    bit          use_hot;
    logic        cmd;
    logic [QNUM_W-1:0] qn;
    logic [DATA_W-1:0] value;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      // three idle profiles, each closed by a full drain
      if (i == 0 || i == RAND_ITEMS / 3 || i == 2 * RAND_ITEMS / 3) begin
        if (i != 0) drain_results();
        if (i == 0) begin
          send_idle_pct = 23; recv_stall_pct = 62;
        end else if (i == RAND_ITEMS / 3) begin
          send_idle_pct = 62; recv_stall_pct = 23;
        end else begin
          send_idle_pct = 0; recv_stall_pct = 0;
        end
      end
      // bias cycles per chunk: fill past overflow, drain past underflow, mix
      if (i % CHUNK_ITEMS == 0) begin
        case ((i / CHUNK_ITEMS) % 4)
          0: enq_pct = 97;
          1: enq_pct = 15;
          2: enq_pct = 50;
          default: enq_pct = 85;
        endcase
        use_hot   = ($urandom_range(2) == 0);
        hot_queue = $urandom_range(QUEUES_DEF - 1);
      end
      cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
      qn  = use_hot ? QNUM_W'(hot_queue) : QNUM_W'($urandom_range(QUEUES_DEF - 1));
      case ($urandom_range(15))
        0: value = 32'h8000_0000;
        1: value = 32'h7fff_ffff;
        2: value = 32'hffff_ffff;
        3: value = 32'h0000_0000;
        default: value = $urandom;
      endcase
      send_command(cmd, qn, value);
    end
  endtask

  initial begin
    sb             = new();
    send_idle_pct  = 23;
    recv_stall_pct = 62;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    command_i      <= CMD_ENQ;
    queue_number_i <= '0;
    push_value_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty queues, queue-number extremes, data extremes, stale tail
    send_command(CMD_DEQ, 3'd0, 32'h1234_5678);
    send_command(CMD_DEQ, 3'd7, 32'hffff_ffff);
    send_command(CMD_ENQ, 3'd0, 32'h8000_0000);
    send_command(CMD_ENQ, 3'd7, 32'h7fff_ffff);
    send_command(CMD_ENQ, 3'd0, 32'hffff_ffff);
    send_command(CMD_ENQ, 3'd7, 32'h0000_0000);
    send_command(CMD_DEQ, 3'd0, 32'h0);
    send_command(CMD_DEQ, 3'd0, 32'h0);
    send_command(CMD_DEQ, 3'd0, 32'h0);
    // queue 0 is empty again with a stale tail pointer
    send_command(CMD_ENQ, 3'd0, 32'ha5a5_a5a5);
    send_command(CMD_ENQ, 3'd0, 32'h5a5a_5a5a);
    send_command(CMD_DEQ, 3'd7, 32'h0);
    send_command(CMD_DEQ, 3'd7, 32'h0);
    send_command(CMD_DEQ, 3'd0, 32'h0);
    send_command(CMD_DEQ, 3'd0, 32'h0);
    send_command(CMD_DEQ, 3'd3, 32'h0);
    drain_results();

    run_random_traffic();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.awaited_pops.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
